@@ hw/rtl/tmvt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tmvt_pkg;

    // tile ram geometry: code and attribute halves, each in its own ram
    localparam int TILE_RAM_BYTES = 2048;
    localparam int HALF_BYTES     = TILE_RAM_BYTES / 2;
    localparam int CELL_W         = $clog2(HALF_BYTES);

    // result target codes
    localparam logic [2:0] TGT_FG_MAP  = 3'd0;
    localparam logic [2:0] TGT_BG_MAP  = 3'd1;
    localparam logic [2:0] TGT_HSCROLL = 3'd2;
    localparam logic [2:0] TGT_VSCROLL = 3'd3;
    localparam logic [2:0] TGT_LATCH   = 3'd4;
    localparam logic [2:0] TGT_BANK    = 3'd5;

    // register decode
    localparam logic [15:0] ADDR_SOUND_LATCH = 16'h3A00;
    localparam logic [15:0] ADDR_HSCROLL_LO  = 16'h3B08;
    localparam logic [15:0] ADDR_VSCROLL_LO  = 16'h3B0A;
    localparam logic [15:0] ADDR_ROM_BANK    = 16'h3E00;
    localparam logic [4:0]  FG_RANGE_TOP     = 5'b00100;
    localparam logic [4:0]  BG_RANGE_TOP     = 5'b00101;

    localparam logic [16:0] BANK_WINDOW_BASE = 17'h0C000;
    localparam logic [7:0]  BANK_DIRECT      = 8'd4;
    localparam logic [7:0]  VSCROLL_OFS_RST  = 8'd16;

    // controller to datapath
    typedef struct packed {
        logic              capture;
        logic              eval;
        logic              clear;
        logic [CELL_W-1:0] clear_addr;
        logic              emit;
        logic [1:0]        emit_idx;
        logic              emit_last;
    } tmvt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic any;
        logic quad;
    } tmvt_status_t;

    // background mirror offsets, in write order
    function automatic logic [12:0] bg_mirror(input logic [1:0] idx);
        logic [12:0] ofs;
        unique case (idx)
            2'd0: ofs = 13'h0000;
            2'd1: ofs = 13'h0400;
            2'd2: ofs = 13'h1000;
            2'd3: ofs = 13'h1440;
            default: ofs = 13'h0000;
        endcase
        return ofs;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tilemap_video_ram_write_translator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// sequence: capture and ram read at the accepting edge, evaluate state, emit state;
//   a new write is taken only back in idle; a changed background tile write gives
//   four mirrored map beats, one per cycle from the emit counter
// reset: busy stays high while the tile rams are swept to zero
// results cannot be stalled; each beat is valid for exactly one cycle

module tilemap_video_ram_write_translator_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] bus_address,
    input  wire logic [7:0]  write_byte,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data,
    output logic             result_valid,
    output logic [2:0]       target,
    output logic [16:0]      out_address,
    output logic [15:0]      out_value,
    output logic             last_of_run
);

    tmvt_pkg::tmvt_cmd_t    cmd;
    tmvt_pkg::tmvt_status_t status;

    // offset register takes a beat any cycle
    assign cfg_ready = 1'b1;

    tmvt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .status (status),
        .cmd    (cmd)
    );

    tmvt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .bus_address (bus_address),
        .write_byte  (write_byte),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .target      (target),
        .out_address (out_address),
        .out_value   (out_value)
    );

    assign result_valid = cmd.emit;
    assign last_of_run  = cmd.emit_last;

endmodule

`default_nettype wire

@@ hw/rtl/tmvt_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tmvt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tmvt_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tmvt_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire tmvt_pkg::tmvt_cmd_t  cmd,
    output tmvt_pkg::tmvt_status_t    status,
    input  wire logic [15:0]          bus_address,
    input  wire logic [7:0]           write_byte,
    input  wire logic                 cfg_valid,
    input  wire logic [7:0]           cfg_data,
    output logic [2:0]                target,
    output logic [16:0]               out_address,
    output logic [15:0]               out_value
);

    localparam int CW = tmvt_pkg::CELL_W;

    // captured beat
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;

    // scroll bytes and offset register
    logic [7:0] hs_reg [2];
    logic [7:0] vs_reg [2];
    logic [7:0] hs_next [2];
    logic [7:0] vs_next [2];
    logic [7:0] vso_reg;

    // pending result
    logic [2:0]  res_target_reg, res_target_next;
    logic [16:0] res_base_reg, res_base_next;
    logic [15:0] res_value_reg, res_value_next;

    // ram ports
    logic [7:0]    fg_code_rd, fg_attr_rd, bg_code_rd, bg_attr_rd;
    logic          fg_code_we, fg_attr_we, bg_code_we, bg_attr_we;
    logic [CW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;

    // decode of the captured beat
    logic          is_fg, is_bg, half_attr;
    logic [CW-1:0] tile_idx;
    logic [4:0]    row, col;
    logic          fg_chg, bg_chg;
    logic [7:0]    fg_code_n, fg_attr_n, bg_code_n, bg_attr_n;
    logic          b_sel;
    logic [8:0]    scroll9;
    logic [9:0]    vsum;
    logic [1:0]    bank2;

    assign is_fg     = (addr_reg[15:11] == tmvt_pkg::FG_RANGE_TOP);
    assign is_bg     = (addr_reg[15:11] == tmvt_pkg::BG_RANGE_TOP);
    assign half_attr = addr_reg[10];
    assign tile_idx  = addr_reg[CW-1:0];
    assign row       = tile_idx[9:5];
    assign col       = tile_idx[4:0];
    assign b_sel     = addr_reg[0];
    assign bank2     = data_reg[1:0];

    // merged tile bytes after the write
    assign fg_code_n = half_attr ? fg_code_rd : data_reg;
    assign fg_attr_n = half_attr ? data_reg : fg_attr_rd;
    assign bg_code_n = half_attr ? bg_code_rd : data_reg;
    assign bg_attr_n = half_attr ? data_reg : bg_attr_rd;
    assign fg_chg    = half_attr ? (fg_attr_rd != data_reg) : (fg_code_rd != data_reg);
    assign bg_chg    = half_attr ? (bg_attr_rd != data_reg) : (bg_code_rd != data_reg);

    // ram writes: clearing sweep or changed byte
    assign fg_code_we = cmd.clear || (cmd.eval && is_fg && !half_attr && fg_chg);
    assign fg_attr_we = cmd.clear || (cmd.eval && is_fg && half_attr && fg_chg);
    assign bg_code_we = cmd.clear || (cmd.eval && is_bg && !half_attr && bg_chg);
    assign bg_attr_we = cmd.clear || (cmd.eval && is_bg && half_attr && bg_chg);
    assign ram_waddr  = cmd.clear ? cmd.clear_addr : tile_idx;
    assign ram_wdata  = cmd.clear ? 8'd0 : data_reg;

    tmvt_ram #(.WIDTH(8), .DEPTH(tmvt_pkg::HALF_BYTES)) u_fg_code (
        .clk(clk), .we(fg_code_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .re(cmd.capture), .raddr(bus_address[CW-1:0]), .rdata(fg_code_rd)
    );

    tmvt_ram #(.WIDTH(8), .DEPTH(tmvt_pkg::HALF_BYTES)) u_fg_attr (
        .clk(clk), .we(fg_attr_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .re(cmd.capture), .raddr(bus_address[CW-1:0]), .rdata(fg_attr_rd)
    );

    tmvt_ram #(.WIDTH(8), .DEPTH(tmvt_pkg::HALF_BYTES)) u_bg_code (
        .clk(clk), .we(bg_code_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .re(cmd.capture), .raddr(bus_address[CW-1:0]), .rdata(bg_code_rd)
    );

    tmvt_ram #(.WIDTH(8), .DEPTH(tmvt_pkg::HALF_BYTES)) u_bg_attr (
        .clk(clk), .we(bg_attr_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .re(cmd.capture), .raddr(bus_address[CW-1:0]), .rdata(bg_attr_rd)
    );

    // evaluate the captured beat
    always_comb
    begin
        status          = '0;
        res_target_next = res_target_reg;
        res_base_next   = res_base_reg;
        res_value_next  = res_value_reg;
        hs_next[0]      = hs_reg[0];
        hs_next[1]      = hs_reg[1];
        vs_next[0]      = vs_reg[0];
        vs_next[1]      = vs_reg[1];
        scroll9         = 9'd0;
        vsum            = 10'd0;
        if (cmd.eval)
        begin
            priority if (is_fg)
            begin
                status.any      = fg_chg;
                res_target_next = tmvt_pkg::TGT_FG_MAP;
                res_base_next   = {6'd0, row, 1'b0, col};
                res_value_next  = {fg_attr_n[3:0], fg_attr_n[5:4], fg_attr_n[7:6], fg_code_n};
            end
            else if (is_bg)
            begin
                status.any      = bg_chg;
                status.quad     = 1'b1;
                res_target_next = tmvt_pkg::TGT_BG_MAP;
                res_base_next   = {7'd0, col, row};
                res_value_next  = {1'b0, bg_attr_n[2:0], bg_attr_n[5:4], bg_attr_n[7:6],
                                   bg_code_n};
            end
            else if (addr_reg == tmvt_pkg::ADDR_SOUND_LATCH)
            begin
                status.any      = 1'b1;
                res_target_next = tmvt_pkg::TGT_LATCH;
                res_base_next   = 17'd0;
                res_value_next  = {8'd0, data_reg};
            end
            else if (addr_reg[15:1] == tmvt_pkg::ADDR_HSCROLL_LO[15:1])
            begin
                status.any      = (hs_reg[b_sel] != data_reg);
                hs_next[b_sel]  = data_reg;
                scroll9         = {hs_next[1][0], hs_next[0]};
                res_target_next = tmvt_pkg::TGT_HSCROLL;
                res_base_next   = 17'd0;
                res_value_next  = {7'd0, scroll9};
            end
            else if (addr_reg[15:1] == tmvt_pkg::ADDR_VSCROLL_LO[15:1])
            begin
                status.any      = (vs_reg[b_sel] != data_reg);
                vs_next[b_sel]  = data_reg;
                scroll9         = {vs_next[1][0], vs_next[0]};
                vsum            = {1'b0, scroll9} + {2'd0, vso_reg};
                res_target_next = tmvt_pkg::TGT_VSCROLL;
                res_base_next   = 17'd0;
                res_value_next  = {6'd0, vsum};
            end
            else if (addr_reg == tmvt_pkg::ADDR_ROM_BANK)
            begin
                status.any      = 1'b1;
                res_target_next = tmvt_pkg::TGT_BANK;
                if (data_reg == tmvt_pkg::BANK_DIRECT)
                begin
                    res_base_next  = 17'd0;
                    res_value_next = 16'd4;
                end
                else
                begin
                    res_base_next  = tmvt_pkg::BANK_WINDOW_BASE + {2'd0, bank2, 13'd0};
                    res_value_next = {14'd0, bank2};
                end
            end
            else
            begin
                status.any = 1'b0;
            end
        end
    end

    // captured beat and pending result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= bus_address;
            data_reg <= write_byte;
        end
        res_target_reg <= res_target_next;
        res_base_reg   <= res_base_next;
        res_value_reg  <= res_value_next;
    end

    // scroll bytes and offset register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hs_reg[0] <= 8'd0;
            hs_reg[1] <= 8'd0;
            vs_reg[0] <= 8'd0;
            vs_reg[1] <= 8'd0;
            vso_reg   <= tmvt_pkg::VSCROLL_OFS_RST;
        end
        else
        begin
            hs_reg[0] <= hs_next[0];
            hs_reg[1] <= hs_next[1];
            vs_reg[0] <= vs_next[0];
            vs_reg[1] <= vs_next[1];
            if (cfg_valid)
            begin
                vso_reg <= cfg_data;
            end
        end
    end

    // result beat fields
    assign target      = res_target_reg;
    assign out_address = res_base_reg + {4'd0, tmvt_pkg::bg_mirror(cmd.emit_idx)};
    assign out_value   = res_value_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tmvt_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tmvt_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire tmvt_pkg::tmvt_status_t status,
    output tmvt_pkg::tmvt_cmd_t         cmd
);

    localparam int CW = tmvt_pkg::CELL_W;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EVAL  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] clr_reg, clr_next;
    logic [1:0]    idx_reg, idx_next;
    logic          quad_reg, quad_next;
    logic          emit_last;

    assign emit_last = !quad_reg || (idx_reg == 2'd3);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        idx_next   = idx_reg;
        quad_next  = quad_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear      = 1'b1;
                cmd.clear_addr = clr_reg;
                clr_next       = clr_reg + {{(CW-1){1'b0}}, 1'b1};
                if (clr_reg == {CW{1'b1}})
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
                if (start)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval  = 1'b1;
                idx_next  = 2'd0;
                quad_next = status.quad;
                state_next = status.any ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit      = 1'b1;
                cmd.emit_idx  = idx_reg;
                cmd.emit_last = emit_last;
                idx_next      = idx_reg + 2'd1;
                if (emit_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            idx_reg   <= 2'd0;
            quad_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            idx_reg   <= idx_next;
            quad_reg  <= quad_next;
        end
    end

endmodule

`default_nettype wire
